/* rtl/evr_pkg.sv */
// ----------------------------------------------------------------------------
// evr_pkg: shared types and constants of the Euler vector rotator
// Coordinate, trig and item types, the cell control word and the
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package evr_pkg;

  // Coordinates are signed Q15.16, trig values signed Q1.16.
  localparam int CRD_W  = 32;
  localparam int TRIG_W = 18;
  localparam int SIN_W  = TRIG_W + 1;
  localparam int PROD_W = CRD_W + SIN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_W = 16;
  localparam int NUM_CELLS = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = TRIG_W;

  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [SIN_W-1:0]  sin_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Axis of one rotation cell; AXIS_NONE passes the vector through.
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_ORDER = 3'd0,
    REG_INVERT     = 3'd1,
    REG_COS_X      = 3'd2,
    REG_SIN_X      = 3'd3,
    REG_COS_Y      = 3'd4,
    REG_SIN_Y      = 3'd5,
    REG_COS_Z      = 3'd6,
    REG_SIN_Z      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } vec_t;

  typedef struct packed {
    crd_t x_in;
    crd_t y_in;
    crd_t z_in;
  } in_item_t;

  typedef struct packed {
    crd_t x_out;
    crd_t y_out;
    crd_t z_out;
  } out_item_t;

  // Control word of one rotation cell.
  typedef struct packed {
    axis_t axis;
    trig_t cos_v;
    sin_t  sin_v;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/evr_cell.sv */
// ----------------------------------------------------------------------------
// evr_cell: one single-axis rotation cell
// Two register stages: the four products, then the sums with floor shift
// and saturation written back into the rotated plane.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_cell import evr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       vld_in,
  input  wire vec_t       vec_in,
  output logic            vld_out,
  output vec_t            vec_out
);

  // Floor shift by the fraction width and saturation to a coordinate.
  function automatic crd_t shift_sat(input sum_t v);
    logic signed [SUM_W-FRAC_W-1:0] sh;
    sh = (SUM_W-FRAC_W)'(v >>> FRAC_W);
    if (sh > (SUM_W-FRAC_W)'(signed'({1'b0, {(CRD_W-1){1'b1}}})))
      return {1'b0, {(CRD_W-1){1'b1}}};
    else if (sh < (SUM_W-FRAC_W)'(signed'({1'b1, {(CRD_W-1){1'b0}}})))
      return {1'b1, {(CRD_W-1){1'b0}}};
    else
      return sh[CRD_W-1:0];
  endfunction

  logic  vld_a;
  vec_t  vec_a;
  axis_t axis_a;
  prod_t p_ci, p_sj, p_cj, p_si;
  crd_t  vi, vj;
  crd_t  new_i, new_j;
  vec_t  vec_next;

  // Pick the coordinates of the rotated plane.
  always_comb begin
    case (ctrl.axis)
      AXIS_X: begin
        vi = vec_in.y;
        vj = vec_in.z;
      end
      AXIS_Y: begin
        vi = vec_in.z;
        vj = vec_in.x;
      end
      AXIS_Z: begin
        vi = vec_in.x;
        vj = vec_in.y;
      end
      default: begin
        vi = vec_in.y;
        vj = vec_in.z;
      end
    endcase
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_a  <= vec_in;
      axis_a <= ctrl.axis;
      p_ci   <= PROD_W'(ctrl.cos_v) * PROD_W'(vi);
      p_sj   <= PROD_W'(ctrl.sin_v) * PROD_W'(vj);
      p_cj   <= PROD_W'(ctrl.cos_v) * PROD_W'(vj);
      p_si   <= PROD_W'(ctrl.sin_v) * PROD_W'(vi);
    end
  end

  // Sum, shift and saturate.
  assign new_i = shift_sat(SUM_W'(p_ci) + SUM_W'(p_sj));
  assign new_j = shift_sat(SUM_W'(p_cj) - SUM_W'(p_si));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_a;
    end
  end

  // Write the rotated pair back; the third coordinate passes unchanged.
  always_comb begin
    vec_next = vec_a;
    case (axis_a)
      AXIS_X: begin
        vec_next.y = new_i;
        vec_next.z = new_j;
      end
      AXIS_Y: begin
        vec_next.z = new_i;
        vec_next.x = new_j;
      end
      AXIS_Z: begin
        vec_next.x = new_i;
        vec_next.y = new_j;
      end
      default: begin
        vec_next = vec_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_out <= vec_next;
    end
  end

  // A valid item reaches the output only from the product stage.
  a_out_from_a: assert property (@(posedge clk) disable iff (rst)
    $rose(vld_out) |-> $past(vld_a))
    else $error("cell output valid without a product stage item");

  // A held pipeline keeps its valid bits.
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!rst && !en) |=> ($stable(vld_out) && $stable(vld_a)))
    else $error("cell valid changed while the pipeline was held");

  // A held output item keeps its coordinates.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (!en && vld_out) |=> $stable(vec_out))
    else $error("cell output item changed while the pipeline was held");

endmodule

`default_nettype wire

/* rtl/euler_vector_rotator_core.sv */
// ----------------------------------------------------------------------------
// euler_vector_rotator_core: three-axis Euler rotation of Q15.16 vectors
// A chain of three rotation cells applies the configured axis sequence.
// ----------------------------------------------------------------------------
// Each item is one vector; the block rotates it about up to three axes in the
// order set by axis_order (forward) or the reverse order with negated sines
// (invert). The chain is six register stages long, and one item can be
// accepted in every cycle while no result waits on result_stall. Each of
// the three cells has a product stage and a sum and saturate stage; the
// whole chain holds while a result waits on result_stall. Configuration
// takes effect at once; the user must write it only when no item is in
// flight, as the block itself does not enforce this.
`default_nettype none

module euler_vector_rotator_core import evr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire in_item_t              item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output out_item_t                  result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [4:0] axis_order;
  logic       invert;
  trig_t      trig [6];

  axis_t      digit [NUM_CELLS];
  cell_ctrl_t ctrl [NUM_CELLS];
  logic       vld_chain [NUM_CELLS+1];
  vec_t       vec_chain [NUM_CELLS+1];
  logic       en;
  logic [4:0] rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_order <= 5'd5;
      invert     <= 1'b0;
      trig[0]    <= TRIG_W'(65536);
      trig[1]    <= '0;
      trig[2]    <= TRIG_W'(65536);
      trig[3]    <= '0;
      trig[4]    <= TRIG_W'(65536);
      trig[5]    <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AXIS_ORDER: axis_order <= cfg_data[4:0];
        REG_INVERT:     invert     <= cfg_data[0];
        REG_COS_X:      trig[0]    <= cfg_data;
        REG_SIN_X:      trig[1]    <= cfg_data;
        REG_COS_Y:      trig[2]    <= cfg_data;
        REG_SIN_Y:      trig[3]    <= cfg_data;
        REG_COS_Z:      trig[4]    <= cfg_data;
        REG_SIN_Z:      trig[5]    <= cfg_data;
        default:        axis_order <= axis_order;
      endcase
    end
  end

  // Split axis_order into its three base-3 digits.
  always_comb begin
    if (axis_order >= 5'd27) begin
      digit[0] = AXIS_NONE;
      rem      = axis_order - 5'd27;
    end else if (axis_order >= 5'd18) begin
      digit[0] = AXIS_Z;
      rem      = axis_order - 5'd18;
    end else if (axis_order >= 5'd9) begin
      digit[0] = AXIS_Y;
      rem      = axis_order - 5'd9;
    end else begin
      digit[0] = AXIS_X;
      rem      = axis_order;
    end
    if (rem >= 5'd6) begin
      digit[1] = AXIS_Z;
      digit[2] = axis_t'(2'(rem - 5'd6));
    end else if (rem >= 5'd3) begin
      digit[1] = AXIS_Y;
      digit[2] = axis_t'(2'(rem - 5'd3));
    end else begin
      digit[1] = AXIS_X;
      digit[2] = axis_t'(2'(rem));
    end
  end

  // Control word for each cell; inverse mode reverses order and negates sines.
  always_comb begin
    for (int k = 0; k < NUM_CELLS; k++) begin
      ctrl[k].axis = invert ? digit[NUM_CELLS-1-k] : digit[k];
      case (ctrl[k].axis)
        AXIS_X: begin
          ctrl[k].cos_v = trig[0];
          ctrl[k].sin_v = SIN_W'(trig[1]);
        end
        AXIS_Y: begin
          ctrl[k].cos_v = trig[2];
          ctrl[k].sin_v = SIN_W'(trig[3]);
        end
        AXIS_Z: begin
          ctrl[k].cos_v = trig[4];
          ctrl[k].sin_v = SIN_W'(trig[5]);
        end
        default: begin
          ctrl[k].cos_v = '0;
          ctrl[k].sin_v = '0;
        end
      endcase
      if (invert) begin
        ctrl[k].sin_v = -ctrl[k].sin_v;
      end
    end
  end

  // The chain moves unless a finished result is being held.
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  assign vld_chain[0] = item_valid;
  assign vec_chain[0] = '{x: item.x_in, y: item.y_in, z: item.z_in};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    evr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctrl    (ctrl[k]),
      .vld_in  (vld_chain[k]),
      .vec_in  (vec_chain[k]),
      .vld_out (vld_chain[k+1]),
      .vec_out (vec_chain[k+1])
    );
  end

  assign result_valid = vld_chain[NUM_CELLS];
  assign result = '{x_out: vec_chain[NUM_CELLS].x,
                    y_out: vec_chain[NUM_CELLS].y,
                    z_out: vec_chain[NUM_CELLS].z};

  // No item enters while a result is held at the output.
  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (rst)
    !(item_valid && !item_stall && result_valid && result_stall))
    else $error("item accepted while a result was held");

  // Reset empties the chain.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // A new result appears only when the chain was enabled.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(en))
    else $error("result appeared while the chain was held");

endmodule

`default_nettype wire

/* tb/euler_vector_rotator_core_tb.sv */
// ----------------------------------------------------------------------------
// euler_vector_rotator_core_tb: self-checking bench for the Euler rotator
// Drives vectors through the rotation chain under many register settings,
// with random gaps on the input side and random stalls on the result side.
// A scoreboard works out each rotated vector in 64-bit arithmetic and
// compares it, field by field, with the item that leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_vector_rotator_core_tb;
  import evr_pkg::*;

  localparam crd_t CRD_MAX = 32'sh7FFF_FFFF;
  localparam crd_t CRD_MIN = 32'sh8000_0000;

  // Q1.16 trig values, including the ones outside the unit range.
  localparam logic [CFG_DATA_W-1:0] Q_ONE        = 18'd65536;
  localparam logic [CFG_DATA_W-1:0] Q_NEG_ONE    = 18'h3_0000;
  localparam logic [CFG_DATA_W-1:0] TRIG_POS_MAX = 18'h1_FFFF;
  localparam logic [CFG_DATA_W-1:0] TRIG_NEG_MAX = 18'h2_0000;
  localparam logic [CFG_DATA_W-1:0] COS_45       = 18'd46341;
  localparam logic [CFG_DATA_W-1:0] COS_30       = 18'd56756;
  localparam logic [CFG_DATA_W-1:0] SIN_30       = 18'd32768;

  // Axis sequences as base-3 digit triples.
  localparam logic [CFG_DATA_W-1:0] ORDER_ZYX     = 18'd21;
  localparam logic [CFG_DATA_W-1:0] ORDER_NONE_YY = 18'h3_FFFF;
  localparam logic [CFG_DATA_W-1:0] ORDER_XXX     = 18'd0;
  localparam logic [CFG_DATA_W-1:0] ORDER_ZZZ     = 18'd26;

  localparam int LATENCY   = 6;
  localparam int NUM_REGS  = 8;
  localparam int PHASES    = 9;
  localparam int PHASE_LEN = 55;

  // Mirrors the register file and predicts the rotated vector of each item.
  class vector_rotation_checker;
    out_item_t  expected_vectors[$];
    int         mismatches;
    logic [4:0] axis_order;
    logic       invert;
    trig_t      cos_tab[3];
    trig_t      sin_tab[3];

    function new();
      mismatches = 0;
      axis_order = 5'd5;
      invert     = 1'b0;
      for (int k = 0; k < 3; k++) begin
        cos_tab[k] = trig_t'(Q_ONE);
        sin_tab[k] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_AXIS_ORDER: axis_order       = d[4:0];
        REG_INVERT:     invert           = d[0];
        REG_COS_X:      cos_tab[AXIS_X]  = trig_t'(d);
        REG_SIN_X:      sin_tab[AXIS_X]  = trig_t'(d);
        REG_COS_Y:      cos_tab[AXIS_Y]  = trig_t'(d);
        REG_SIN_Y:      sin_tab[AXIS_Y]  = trig_t'(d);
        REG_COS_Z:      cos_tab[AXIS_Z]  = trig_t'(d);
        REG_SIN_Z:      sin_tab[AXIS_Z]  = trig_t'(d);
        default: ;
      endcase
    endfunction

    // Floor shift by the fraction width, then clamp to a 32-bit coordinate.
    function longint shift_sat(longint v);
      longint r;
      r = v >>> FRAC_W;
      if (r > longint'(CRD_MAX)) r = longint'(CRD_MAX);
      if (r < longint'(CRD_MIN)) r = longint'(CRD_MIN);
      return r;
    endfunction

    function out_item_t rotate_vector(in_item_t it);
      longint    v[3];
      longint    c, s, a, b;
      int        i, j, digit;
      axis_t     ax[3];
      axis_t     axis;
      out_item_t o;
      v[0] = it.x_in;
      v[1] = it.y_in;
      v[2] = it.z_in;
      digit = axis_order / 9;
      ax[0] = axis_t'(digit[1:0]);
      digit = (axis_order / 3) % 3;
      ax[1] = axis_t'(digit[1:0]);
      digit = axis_order % 3;
      ax[2] = axis_t'(digit[1:0]);
      // Inverse mode walks the sequence backward with negated sines.
      for (int k = 0; k < 3; k++) begin
        axis = invert ? ax[2-k] : ax[k];
        if (axis == AXIS_NONE) continue;
        case (axis)
          AXIS_X: begin i = 1; j = 2; end
          AXIS_Y: begin i = 2; j = 0; end
          default: begin i = 0; j = 1; end
        endcase
        c = cos_tab[axis];
        s = sin_tab[axis];
        if (invert) s = -s;
        a = shift_sat(c * v[i] + s * v[j]);
        b = shift_sat(c * v[j] - s * v[i]);
        v[i] = a;
        v[j] = b;
      end
      o.x_out = crd_t'(v[0]);
      o.y_out = crd_t'(v[1]);
      o.z_out = crd_t'(v[2]);
      return o;
    endfunction

    function void note_vector(in_item_t it);
      expected_vectors.push_back(rotate_vector(it));
    endfunction

    function void check_rotated(out_item_t got);
      out_item_t want;
      if (expected_vectors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result item x=%0d y=%0d z=%0d", $realtime,
                   got.x_out, got.y_out, got.z_out);
        return;
      end
      want = expected_vectors.pop_front();
      if (got.x_out !== want.x_out || got.y_out !== want.y_out ||
          got.z_out !== want.z_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] rotated vector differs: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                   $realtime, want.x_out, want.y_out, want.z_out,
                   got.x_out, got.y_out, got.z_out);
      end
    endfunction

    function int pending();
      return expected_vectors.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_stall;
  out_item_t             result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vector_rotation_checker sb = new();

  logic [CFG_DATA_W-1:0] regs_v [NUM_REGS];
  int gap_pct;
  int stall_pct;
  int stall_left;

  euler_vector_rotator_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock with a period of 12.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result-side stalls come in bursts of random length.
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      result_stall <= 1'b1;
      stall_left = $urandom_range(9, 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Both handshakes are observed here at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_vector(item);
      if (result_valid && !result_stall) sb.check_rotated(result);
    end
  end

  function automatic crd_t rand_crd();
    case ($urandom_range(3))
      0: return crd_t'($urandom_range(2097152) - 1048576);
      1: begin
        case ($urandom_range(4))
          0: return CRD_MAX;
          1: return CRD_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return crd_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_trig();
    case ($urandom_range(9))
      0: return CFG_DATA_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return Q_ONE;
          1: return Q_NEG_ONE;
          2: return TRIG_POS_MAX;
          default: return TRIG_NEG_MAX;
        endcase
      end
      default: return CFG_DATA_W'($urandom_range(131072) - 65536);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // Writes every register from regs_v; only called with nothing in flight.
  task automatic program_regs();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= regs_v[r];
      @(posedge clk);
      sb.set_reg(reg_idx_t'(r), regs_v[r]);
    end
    cfg_we <= 1'b0;
  endtask

  // Presents one vector and holds it until the block takes it, then may idle for a random gap.
  task automatic send_vec(input crd_t x, input crd_t y, input crd_t z);
    in_item_t it;
    it.x_in = x;
    it.y_in = y;
    it.z_in = z;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted vector has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Hard limit on the run time.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    result_stall = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    stall_left   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings give the identity rotation; push the coordinate extremes.
    send_vec(CRD_MAX, CRD_MAX, CRD_MAX);
    send_vec(CRD_MIN, CRD_MIN, CRD_MIN);
    send_vec('0, '0, '0);
    send_vec(1, -1, CRD_MIN);
    drain_results();

    // Reverse axis order with unit trig values that push the sums to saturation.
    regs_v[REG_AXIS_ORDER] = ORDER_ZYX;
    regs_v[REG_INVERT]     = '0;
    regs_v[REG_COS_X]      = Q_ONE;
    regs_v[REG_SIN_X]      = Q_ONE;
    regs_v[REG_COS_Y]      = Q_NEG_ONE;
    regs_v[REG_SIN_Y]      = Q_ONE;
    regs_v[REG_COS_Z]      = Q_ONE;
    regs_v[REG_SIN_Z]      = Q_NEG_ONE;
    program_regs();
    send_vec(CRD_MAX, CRD_MAX, CRD_MAX);
    send_vec(CRD_MIN, CRD_MIN, CRD_MIN);
    send_vec(CRD_MAX, CRD_MIN, 1);
    drain_results();

    // Out-of-range first digit passes through; trig values at the 18-bit limits.
    regs_v[REG_AXIS_ORDER] = ORDER_NONE_YY;
    regs_v[REG_INVERT]     = 18'h3_FFFF;
    regs_v[REG_COS_X]      = TRIG_POS_MAX;
    regs_v[REG_SIN_X]      = TRIG_NEG_MAX;
    regs_v[REG_COS_Y]      = TRIG_NEG_MAX;
    regs_v[REG_SIN_Y]      = TRIG_POS_MAX;
    regs_v[REG_COS_Z]      = '0;
    regs_v[REG_SIN_Z]      = TRIG_NEG_MAX;
    program_regs();
    send_vec(CRD_MAX, CRD_MIN, CRD_MAX);
    send_vec(rand_crd(), rand_crd(), rand_crd());
    send_vec(-1, -1, -1);
    drain_results();

    // Repeated x axis in inverse mode at 45 degrees.
    regs_v[REG_AXIS_ORDER] = ORDER_XXX;
    regs_v[REG_INVERT]     = 18'd1;
    regs_v[REG_COS_X]      = COS_45;
    regs_v[REG_SIN_X]      = COS_45;
    program_regs();
    send_vec(32'sd65536, 32'sd131072, -32'sd65536);
    send_vec(rand_crd(), rand_crd(), rand_crd());
    send_vec(rand_crd(), rand_crd(), rand_crd());
    drain_results();

    // Repeated z axis forward at 30 degrees, with some back-pressure.
    gap_pct   = 15;
    stall_pct = 15;
    regs_v[REG_AXIS_ORDER] = ORDER_ZZZ;
    regs_v[REG_INVERT]     = '0;
    regs_v[REG_COS_Z]      = COS_30;
    regs_v[REG_SIN_Z]      = SIN_30;
    program_regs();
    send_vec(32'sd65536, '0, 32'sd65536);
    send_vec(rand_crd(), rand_crd(), rand_crd());
    send_vec(rand_crd(), rand_crd(), rand_crd());
    drain_results();

    // Random settings per phase; the last phases run with no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      regs_v[REG_AXIS_ORDER] = CFG_DATA_W'($urandom);
      regs_v[REG_INVERT]     = CFG_DATA_W'($urandom);
      for (int r = REG_COS_X; r <= REG_SIN_Z; r++) regs_v[r] = rand_trig();
      program_regs();
      if (p >= PHASES - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Once in the run, hold off mid-phase until the chain is empty.
        if (p == 2 && n == PHASE_LEN / 2) drain_results();
        send_vec(rand_crd(), rand_crd(), rand_crd());
      end
      drain_results();
    end

    repeat (LATENCY + 2) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
